/* sv/refcounted_probe_cache_table_assert.svh */
// assertion macros for the probe cache table checker
`ifndef REFCOUNTED_PROBE_CACHE_TABLE_ASSERT_SVH
`define REFCOUNTED_PROBE_CACHE_TABLE_ASSERT_SVH

// property checked at every clock edge outside reset
`define RPCT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("probe cache table assertion failed");

// property checked at every clock edge, reset included
`define RPCT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("probe cache table reset assertion failed");

`endif

/* sv/rpct_pkg.sv */
// shared types and codes of the probe cache table
`default_nettype none

package rpct_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int NUM_W     = 32;
  localparam int SLOT_W    = 6;
  localparam int REFS_W    = 8;
  localparam int STATUS_W  = 4;
  localparam int LIMIT_W   = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd1;
  localparam logic [REFS_W-1:0]  REFS_MAX    = 8'hFF;

  // action codes
  localparam logic [1:0] ACT_REQUEST = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_MARK    = 2'd2;
  localparam logic [1:0] ACT_FLUSH   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_HIT        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_MISS       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FREE    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_MARKED     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_FLUSH_WB   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FLUSH_NONE = 4'd8;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 4'd9;

  typedef struct packed {
    logic [1:0]        action;
    logic [NUM_W-1:0]  object_number;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic                load_needed;
    logic                writeback_needed;
    logic [NUM_W-1:0]    writeback_number;
    logic                last;
  } out_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [REFS_W-1:0] refs;
    logic              dirty;
  } entry_t;

endpackage

`default_nettype wire

/* sv/rpct_hash.sv */
// iterative start slot unit: object number modulo the slot count
`default_nettype none

module rpct_hash import rpct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   rem
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int R_W     = IDX_W + 1;
  localparam int DIGIT_W = 4;
  localparam int STEPS   = NUM_W / DIGIT_W;
  localparam int CNT_W   = $clog2(STEPS);
  localparam logic [R_W-1:0] SLOTS_R = R_W'(SLOTS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] sh;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] r_next;

  // four remainder steps per cycle, most significant bits first
  always_comb begin
    logic [R_W-1:0] acc;
    acc = {1'b0, r};
    for (int j = 0; j < DIGIT_W; j++) begin
      acc = {acc[R_W-2:0], sh[NUM_W-1-j]};
      if (acc >= SLOTS_R) begin
        acc = acc - SLOTS_R;
      end
    end
    r_next = acc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= num;
        r    <= '0;
      end else if (busy) begin
        r   <= r_next;
        sh  <= sh << DIGIT_W;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

endmodule

`default_nettype wire

/* sv/refcounted_probe_cache_table.sv */
// top level of the reference counted linear probing cache table
`default_nettype none

// Slot table with reference counts. Entries live in one single-port-read
// slot memory (read data registered), valid bits in flops. One input
// item is worked on at a time. A release or mark-dirty reads its slot,
// then updates it. A request finds its start slot with an iterative
// modulo unit, then streams one memory read per cycle through the probe
// sequence, looking for a hit and remembering the first free slot in the
// same pass; a hit ends the walk early. A flush reads every slot with a
// read/check step pair and can be held by an output stall. A finished
// result waits in the output register while the next item is taken.
module refcounted_probe_cache_table import rpct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W:0]   SLOTS_R   = (IDX_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_SCAN, S_UPD, S_FL_RD, S_FL_CHK, S_FL_END, S_EMIT
  } state_t;

  // input slot index wrapped into the table
  function automatic logic [IDX_W-1:0] slot_wrap(input logic [SLOT_W-1:0] s);
    logic [IDX_W:0] acc;
    acc = '0;
    for (int j = SLOT_W - 1; j >= 0; j--) begin
      acc = {acc[IDX_W-1:0], s[j]};
      if (acc >= SLOTS_R) begin
        acc = acc - SLOTS_R;
      end
    end
    return acc[IDX_W-1:0];
  endfunction

  function automatic out_t mk_res(input logic [STATUS_W-1:0] st,
                                  input logic [IDX_W-1:0] sl,
                                  input logic ld, input logic wb,
                                  input logic [NUM_W-1:0] wbn,
                                  input logic lst);
    out_t o;
    o.status           = st;
    o.result_slot      = SLOT_W'(sl);
    o.load_needed      = ld;
    o.writeback_needed = wb;
    o.writeback_number = wbn;
    o.last             = lst;
    return o;
  endfunction

  state_t             state;
  logic [LIMIT_W-1:0] reserved_limit;
  logic [1:0]         act;
  logic [NUM_W-1:0]   num;
  logic [IDX_W-1:0]   probe;
  logic [CNT_W-1:0]   kcnt;
  logic               chk_vld;
  logic               have_free;
  logic [IDX_W-1:0]   free_slot;
  logic               free_wb;
  logic [NUM_W-1:0]   free_num;
  logic               pend;
  out_t               res;
  logic [SLOTS-1:0]   valid_bits;

  // slot memory
  entry_t             mem [SLOTS];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_slot;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               in_fire;
  logic               out_free;
  logic [IDX_W-1:0]   in_slot;
  logic               reserved;
  logic               hash_start;
  logic               hash_done;
  logic [IDX_W-1:0]   hash_rem;
  logic               ent_valid;
  logic [REFS_W-1:0]  ent_refs;
  logic               ent_dirty;
  logic               hit;
  logic               scan_issue;
  logic               scan_done;
  logic [IDX_W-1:0]   probe_inc;
  logic               fl_go;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign in_slot    = slot_wrap(in_data.slot);
  assign reserved   = (in_data.object_number <= NUM_W'(reserved_limit));
  assign hash_start = in_fire && (in_data.action == ACT_REQUEST) && !reserved;

  // entry as seen through its valid bit
  assign ent_valid = valid_bits[rd_slot];
  assign ent_refs  = ent_valid ? rd_data.refs : '0;
  assign ent_dirty = ent_valid && rd_data.dirty;
  assign hit       = ent_valid && (rd_data.number == num);

  assign scan_issue = (state == S_SCAN) && (kcnt != SLOTS_C);
  assign scan_done  = (state == S_SCAN) && !chk_vld && (kcnt == SLOTS_C);
  assign probe_inc  = (probe == LAST_SLOT) ? '0 : probe + 1'b1;
  assign fl_go      = !ent_dirty || !pend || out_free;

  rpct_hash #(.SLOTS(SLOTS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .num   (in_data.object_number),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  // memory read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = probe;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_fire && ((in_data.action == ACT_RELEASE) ||
                              (in_data.action == ACT_MARK));
        rd_addr = in_slot;
      end
      S_SCAN:  rd_en = scan_issue;
      S_FL_RD: rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  // read-modify-write back into the slot memory
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_slot;
    wr_data = rd_data;
    unique case (state)
      S_SCAN: begin
        if (chk_vld && hit && (rd_data.refs != REFS_MAX)) begin
          wr_en        = 1'b1;
          wr_data.refs = rd_data.refs + 1'b1;
        end else if (scan_done && have_free) begin
          wr_en          = 1'b1;
          wr_addr        = free_slot;
          wr_data.number = num;
          wr_data.refs   = REFS_W'(1);
          wr_data.dirty  = 1'b0;
        end
      end
      S_UPD: begin
        if (act == ACT_RELEASE && ent_refs != '0) begin
          wr_en        = 1'b1;
          wr_data.refs = rd_data.refs - 1'b1;
        end else if (act == ACT_MARK && ent_valid) begin
          wr_en         = 1'b1;
          wr_data.dirty = 1'b1;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_slot <= rd_addr;
    end
  end

  // sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      reserved_limit <= LIMIT_RESET;
      valid_bits     <= '0;
      out_valid      <= 1'b0;
      chk_vld        <= 1'b0;
      have_free      <= 1'b0;
      pend           <= 1'b0;
      kcnt           <= '0;
    end else begin
      if (cfg_we) begin
        reserved_limit <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            act <= in_data.action;
            num <= in_data.object_number;
            unique case (in_data.action)
              ACT_REQUEST: begin
                if (reserved) begin
                  res   <= mk_res(ST_REJECTED, '0, 1'b0, 1'b0, '0, 1'b1);
                  state <= S_EMIT;
                end else begin
                  state <= S_HASH;
                end
              end
              ACT_RELEASE, ACT_MARK: begin
                probe <= in_slot;
                state <= S_UPD;
              end
              default: begin
                probe <= '0;
                pend  <= 1'b0;
                state <= S_FL_RD;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            probe     <= hash_rem;
            kcnt      <= '0;
            chk_vld   <= 1'b0;
            have_free <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld <= scan_issue;
          if (scan_issue) begin
            probe <= probe_inc;
            kcnt  <= kcnt + 1'b1;
          end
          if (chk_vld) begin
            // hit ends the walk, else remember the first free slot
            if (hit) begin
              res <= mk_res((rd_data.refs == REFS_MAX) ? ST_OVERFLOW : ST_HIT,
                            rd_slot, 1'b0, 1'b0, '0, 1'b1);
              state <= S_EMIT;
            end else if (ent_refs == '0 && !have_free) begin
              have_free <= 1'b1;
              free_slot <= rd_slot;
              free_wb   <= ent_dirty;
              free_num  <= rd_data.number;
            end
          end else if (kcnt == SLOTS_C) begin
            if (have_free) begin
              valid_bits[free_slot] <= 1'b1;
              res <= mk_res(ST_MISS, free_slot, 1'b1, free_wb,
                            free_wb ? free_num : '0, 1'b1);
            end else begin
              res <= mk_res(ST_NO_FREE, '0, 1'b0, 1'b0, '0, 1'b1);
            end
            state <= S_EMIT;
          end
        end
        S_UPD: begin
          if (act == ACT_RELEASE) begin
            res <= mk_res((ent_refs == '0) ? ST_UNDERFLOW : ST_RELEASED,
                          rd_slot, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            res <= mk_res(ST_MARKED, rd_slot, 1'b0, 1'b0, '0, 1'b1);
          end
          state <= S_EMIT;
        end
        S_FL_RD: begin
          state <= S_FL_CHK;
        end
        S_FL_CHK: begin
          // hold one dirty slot back so the final one can carry last
          if (ent_dirty && fl_go) begin
            if (pend) begin
              out_valid <= 1'b1;
              out_data  <= res;
            end
            res  <= mk_res(ST_FLUSH_WB, rd_slot, 1'b0, 1'b1, rd_data.number, 1'b0);
            pend <= 1'b1;
          end
          if (fl_go) begin
            if (probe == LAST_SLOT) begin
              state <= S_FL_END;
            end else begin
              probe <= probe_inc;
              state <= S_FL_RD;
            end
          end
        end
        S_FL_END: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pend) begin
              out_data      <= res;
              out_data.last <= 1'b1;
            end else begin
              out_data <= mk_res(ST_FLUSH_NONE, '0, 1'b0, 1'b0, '0, 1'b1);
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/rpct_checker.sv */
// port level checker for the probe cache table, bound to the top level
`default_nettype none

`include "refcounted_probe_cache_table_assert.svh"

module rpct_checker import rpct_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input in_t                in_data,
  input logic               out_valid,
  input logic               out_ready,
  input out_t               out_data,
  input logic               cfg_we,
  input logic [LIMIT_W-1:0] cfg_wdata
);

  // a stalled result holds
  `RPCT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // reset leaves no result pending and the input open
  `RPCT_ASSERT_ALWAYS(a_rst_clear, rst |=> !out_valid && in_ready)

  // a load is asked for on a miss and only there
  `RPCT_ASSERT(a_load_miss, out_valid |-> out_data.load_needed == (out_data.status == ST_MISS))

  // no write-back number without a write-back
  `RPCT_ASSERT(a_wb_zero, out_valid && !out_data.writeback_needed |-> out_data.writeback_number == '0)

  // one item at a time: an accepted item closes the input
  `RPCT_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready)

endmodule

bind refcounted_probe_cache_table rpct_checker u_rpct_checker (.*);

`default_nettype wire
